// ----- hw/rtl/lru_page_replacement_assert.svh -----
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shorthand for the concurrent checks of the page replacement block.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define LRU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru_page_replacement check failed");
// Consequent must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru_page_replacement check failed");
`else
`define LRU_ASSERT_SAME(label, clk, rst, ante, cons)
`define LRU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- hw/rtl/lru_pr_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement package
// Sizes, reset values and the control bundle handed to each list cell.
// ----------------------------------------------------------------------------
`default_nettype none

package lru_pr_pkg;

   localparam int MaxSlots   = 8;
   localparam int PageCount  = 256;
   localparam int PageWidth  = 8;
   localparam int CountWidth = $clog2(MaxSlots + 1);
   localparam int FaultWidth = 16;
   localparam int SlotsWidth = 4;

   localparam logic [SlotsWidth-1:0] ActiveSlotsReset = 4'd8;
   localparam logic [FaultWidth-1:0] FaultMax         = 16'hFFFF;

   typedef logic [PageWidth-1:0]  page_type;
   typedef logic [CountWidth-1:0] count_type;

   typedef struct packed {
      logic valid;     // entry holds a resident page
      logic evict;     // replacement: every cell below the target shifts
      logic load;      // this cell takes the requested page
      logic shift_en;  // this cell lies below the target and a request is taken
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/lru_pr_cell.sv -----
// ----------------------------------------------------------------------------
// LRU list cell
// Holds one entry of the recency list, compares it with the request and
// passes the match chain upward; takes its upper neighbor's entry on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_pr_cell (
   input  wire logic                  clock,
   input  wire lru_pr_pkg::page_type  page,
   input  wire lru_pr_pkg::page_type  upper_entry,
   input  wire lru_pr_pkg::cell_ctrl_type ctrl,
   input  wire logic                  chain_in,
   output logic                       chain_out,
   output lru_pr_pkg::page_type       entry
);

   lru_pr_pkg::page_type entry_ff;
   lru_pr_pkg::page_type entry_in;
   logic                 shift;

   // A hit at or below this cell means everything from the hit upward moves down.
   assign chain_out = chain_in | (ctrl.valid & (entry_ff == page));
   assign shift     = chain_out | ctrl.evict;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         entry_in = page;
      end else if (ctrl.shift_en && shift) begin
         entry_in = upper_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement
// Recency-ordered page list with replacement fault counter.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req_page_number) carries one page
//   request. Each request produces exactly one response on the rsp_ channel:
//   hit flag, evicted page (valid flag and number) and the running count of
//   replacement faults after this request.
//   The list is a row of cells, one per frame; all cells compare the request
//   in parallel and shift together, so a request is taken every cycle while req_stall is low
//   and its response appears in the output register in the cycle after acceptance.
//   req_stall rises only while a response is held and rsp_stall is high; the
//   held response stays unchanged until taken.
//   The csr_ channel writes the number of frames in use (0 acts as 1, values
//   above the capacity act as the capacity); write it only while idle.
//   Reset empties the list, clears the fault count and sets eight frames.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_page_replacement_assert.svh"

module lru_page_replacement (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [lru_pr_pkg::PageWidth-1:0]    req_page_number,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_hit,
   output logic                                     rsp_evicted_valid,
   output logic [lru_pr_pkg::PageWidth-1:0]         rsp_evicted_page,
   output logic [lru_pr_pkg::FaultWidth-1:0]        rsp_fault_total,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lru_pr_pkg::SlotsWidth-1:0]   csr_active_slots
);

   localparam int N = lru_pr_pkg::MaxSlots;

   logic [lru_pr_pkg::SlotsWidth-1:0] active_ff;
   lru_pr_pkg::count_type             occ_ff;
   lru_pr_pkg::count_type             occ_in;
   logic [lru_pr_pkg::FaultWidth-1:0] fault_ff;
   logic [lru_pr_pkg::FaultWidth-1:0] fault_in;

   logic                              rsp_valid_ff;
   logic                              hit_ff;
   logic                              evict_ff;
   lru_pr_pkg::page_type              evict_page_ff;

   lru_pr_pkg::count_type             limit;
   lru_pr_pkg::count_type             target;
   logic                              req_fire;
   logic                              hit;
   logic                              full;
   logic                              evict;

   lru_pr_pkg::page_type              entries [N];
   lru_pr_pkg::page_type              uppers  [N];
   logic [N:0]                        chain;
   lru_pr_pkg::cell_ctrl_type         ctrls   [N];

   assign req_fire  = req_valid & ~req_stall;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (active_ff == '0) begin
         limit = lru_pr_pkg::count_type'(1);
      end else if (32'(active_ff) > 32'(N)) begin
         limit = lru_pr_pkg::count_type'(N);
      end else begin
         limit = lru_pr_pkg::count_type'(active_ff);
      end
   end

   assign chain[0] = 1'b0;
   assign hit      = chain[N];
   assign full     = occ_ff >= limit;
   assign evict    = ~hit & full;
   // Append goes to the first free slot; hit and replacement end at the top.
   assign target   = (~hit & ~full) ? occ_ff : occ_ff - lru_pr_pkg::count_type'(1);

   for (genvar i = 0; i < N; i++) begin : g_cell
      always_comb begin
         ctrls[i].valid    = lru_pr_pkg::count_type'(i) < occ_ff;
         ctrls[i].evict    = evict;
         ctrls[i].load     = req_fire & (lru_pr_pkg::count_type'(i) == target);
         ctrls[i].shift_en = req_fire & (lru_pr_pkg::count_type'(i) < target);
      end

      if (i == N - 1) begin : g_top
         assign uppers[i] = req_page_number;
      end else begin : g_mid
         assign uppers[i] = entries[i+1];
      end

      lru_pr_cell u_cell (
         .clock       (clock),
         .page        (req_page_number),
         .upper_entry (uppers[i]),
         .ctrl        (ctrls[i]),
         .chain_in    (chain[i]),
         .chain_out   (chain[i+1]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      occ_in   = occ_ff;
      fault_in = fault_ff;
      if (req_fire) begin
         if (~hit & ~full) begin
            occ_in = occ_ff + lru_pr_pkg::count_type'(1);
         end
         if (evict && fault_ff != lru_pr_pkg::FaultMax) begin
            fault_in = fault_ff + lru_pr_pkg::FaultWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= lru_pr_pkg::ActiveSlotsReset;
         occ_ff       <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            active_ff <= csr_active_slots;
         end
         occ_ff   <= occ_in;
         fault_ff <= fault_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         hit_ff        <= hit;
         evict_ff      <= evict;
         evict_page_ff <= evict ? entries[0] : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_evicted_valid = evict_ff;
   assign rsp_evicted_page  = evict_page_ff;
   assign rsp_fault_total   = fault_ff;

   `LRU_ASSERT_SAME(a_occ_bound, clock, reset, 1'b1, 32'(occ_ff) <= 32'(N))
   `LRU_ASSERT_SAME(a_hit_no_evict, clock, reset, rsp_valid_ff, !(hit_ff && evict_ff))
   `LRU_ASSERT_NEXT(a_fault_step, clock, reset, req_fire && evict && fault_ff != lru_pr_pkg::FaultMax, fault_ff == $past(fault_ff) + lru_pr_pkg::FaultWidth'(1))
   `LRU_ASSERT_NEXT(a_occ_hold, clock, reset, req_fire && (hit || full), $stable(occ_ff))

endmodule

`default_nettype wire

// ----- sim/lru_page_replacement_tb.sv -----
// ----------------------------------------------------------------------------
// LRU page replacement testbench
// Sends page requests with random gaps against random response stalls. Each
// response is checked against an in-bench copy of the recency list, and the
// frame count is changed between phases. A short run at one frame makes every
// request a replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {
      ITEM_PAGE,
      ITEM_SLOTS
   } item_kind_type;

   typedef struct packed {
      item_kind_type                       kind;
      lru_pr_pkg::page_type                page;
      logic [lru_pr_pkg::SlotsWidth-1:0]   slots;
      logic                                steady;
   } page_item_type;

   typedef struct packed {
      logic                                hit;
      logic                                evicted_valid;
      lru_pr_pkg::page_type                evicted_page;
      logic [lru_pr_pkg::FaultWidth-1:0]   fault_total;
   } page_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   lru_pr_pkg::page_type                req_page_number = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic                                rsp_hit;
   logic                                rsp_evicted_valid;
   lru_pr_pkg::page_type                rsp_evicted_page;
   logic [lru_pr_pkg::FaultWidth-1:0]   rsp_fault_total;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [lru_pr_pkg::SlotsWidth-1:0]   csr_active_slots = '0;

   page_item_type                       page_stream[$];
   page_result_type                     predicted_results[$];
   int                                  results_owed = 0;
   logic                                quiet_mode = 1'b0;
   int                                  errors = 0;

   // Shadow of the block's recency list, position 0 least recent.
   lru_pr_pkg::page_type                recency[lru_pr_pkg::MaxSlots];
   int                                  resident = 0;
   logic [lru_pr_pkg::FaultWidth-1:0]   fault_count = '0;
   logic [lru_pr_pkg::SlotsWidth-1:0]   frames_cfg = lru_pr_pkg::ActiveSlotsReset;

   lru_page_replacement DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_slots  (csr_active_slots)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #20_000_000;
      $display("lru_page_replacement test failed");
      $finish;
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 30);
   endfunction

   function automatic page_result_type replace_page(lru_pr_pkg::page_type page);
      int              limit;
      int              pos;
      page_result_type res;
      limit = (frames_cfg == 0) ? 1 :
              ((frames_cfg > lru_pr_pkg::MaxSlots) ? lru_pr_pkg::MaxSlots :
               int'(frames_cfg));
      res = '0;
      pos = -1;
      for (int i = 0; i < resident; i++) begin
         if (pos < 0 && recency[i] == page) pos = i;
      end
      if (pos >= 0) begin
         res.hit = 1'b1;
         for (int i = pos; i + 1 < resident; i++) recency[i] = recency[i + 1];
         recency[resident - 1] = page;
      end else if (resident < limit) begin
         recency[resident] = page;
         resident++;
      end else begin
         // A lowered limit leaves the list over-full; it is replaced in place.
         res.evicted_valid = 1'b1;
         res.evicted_page = recency[0];
         for (int i = 0; i + 1 < resident; i++) recency[i] = recency[i + 1];
         recency[resident - 1] = page;
         if (fault_count != lru_pr_pkg::FaultMax) fault_count++;
      end
      res.fault_total = fault_count;
      return res;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic add_page(input lru_pr_pkg::page_type page, input logic steady);
      page_item_type item;
      item = '{kind: ITEM_PAGE, page: page, slots: '0, steady: steady};
      page_stream = {page_stream, item};
   endtask

   task automatic add_slots(input logic [lru_pr_pkg::SlotsWidth-1:0] slots);
      page_item_type item;
      item = '{kind: ITEM_SLOTS, page: '0, slots: slots, steady: 1'b0};
      page_stream = {page_stream, item};
   endtask

   // Request driver. Frame count writes wait until every response is back.
   always @(posedge clock) begin : drive_requests
      page_item_type item;
      logic          next_req_valid;
      logic          next_csr_valid;
      int unsigned   hold_off;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
         hold_off = 0;
      end else begin
         next_req_valid = req_valid && req_stall;
         next_csr_valid = csr_valid && !csr_ready;
         if (!next_req_valid && !next_csr_valid) begin
            if (hold_off > 0) begin
               hold_off--;
            end else if (page_stream.size() > 0) begin
               item = page_stream[0];
               if (item.kind == ITEM_PAGE) begin
                  page_stream.delete(0);
                  next_req_valid = 1'b1;
                  req_page_number <= item.page;
                  quiet_mode <= item.steady;
                  hold_off = item.steady ? 0 : idle_length();
               end else if (!req_valid && results_owed == 0) begin
                  page_stream.delete(0);
                  next_csr_valid = 1'b1;
                  csr_active_slots <= item.slots;
               end
            end
         end
         req_valid <= next_req_valid;
         csr_valid <= next_csr_valid;
      end
   end

   // Response monitor: predicts each accepted request, checks each response.
   always @(posedge clock) begin : watch_responses
      page_result_type want;
      int unsigned     stall_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (csr_valid && csr_ready) frames_cfg = csr_active_slots;
         if (req_valid && !req_stall) begin
            predicted_results = {predicted_results, replace_page(req_page_number)};
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, %s",
                        $time, "actual follows");
               $display("   %0b %0b %0d %0d", rsp_hit, rsp_evicted_valid,
                        rsp_evicted_page, rsp_fault_total);
               errors++;
            end else begin
               want = predicted_results[0];
               predicted_results.delete(0);
               compare_field("hit", 32'(want.hit), 32'(rsp_hit));
               compare_field("evicted_valid", 32'(want.evicted_valid),
                             32'(rsp_evicted_valid));
               compare_field("evicted_page", 32'(want.evicted_page),
                             32'(rsp_evicted_page));
               compare_field("fault_total", 32'(want.fault_total),
                             32'(rsp_fault_total));
            end
         end
         results_owed <= predicted_results.size();
         if (quiet_mode) begin
            stall_left = 0;
            rsp_stall <= 1'b0;
         end else begin
            // A run of stalled cycles, then one free cycle.
            if (stall_left == 0) stall_left = idle_length() + 1;
            stall_left--;
            rsp_stall <= (stall_left != 0);
         end
      end
   end

   initial begin : build_stream
      logic [lru_pr_pkg::SlotsWidth-1:0] phase_slots[16];
      lru_pr_pkg::page_type              base;
      int unsigned                       span;
      logic                              steady;
      phase_slots = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd8, 4'd2, 4'd7,
                      4'd15, 4'd3, 4'd0, 4'd6, 4'd5, 4'd8, 4'd1, 4'd15};

      // Two frames: fill, hit, replace.
      add_slots(4'd2);
      add_page(8'h00, 1'b0);
      add_page(8'hFF, 1'b0);
      add_page(8'h00, 1'b0);
      add_page(8'hAA, 1'b0);
      add_page(8'h55, 1'b0);
      add_page(8'hAA, 1'b0);
      // An oversized count acts as the full capacity.
      add_slots(4'd15);
      add_page(8'h01, 1'b0);
      add_page(8'h02, 1'b0);
      add_page(8'h04, 1'b0);
      add_page(8'h08, 1'b0);
      add_page(8'h10, 1'b0);
      add_page(8'h20, 1'b0);
      add_page(8'h40, 1'b0);
      add_page(8'h80, 1'b0);
      add_page(8'h01, 1'b0);
      // Zero acts as one frame, well below the current occupancy.
      add_slots(4'd0);
      add_page(8'h33, 1'b0);
      add_page(8'h20, 1'b0);
      add_page(8'h77, 1'b0);

      // Random phases: mostly a small working set so that hits are common.
      for (int ph = 0; ph < 16; ph++) begin
         add_slots(phase_slots[ph]);
         base = $urandom_range(0, 255);
         span = $urandom_range(2, 12);
         steady = (ph % 5 == 3);
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(0, 99) < 75)
               add_page(base + lru_pr_pkg::page_type'($urandom_range(0, span - 1)), steady);
            else
               add_page(lru_pr_pkg::page_type'($urandom), steady);
         end
      end

      // Cycle sixteen pages through one frame so that every request replaces.
      add_slots(4'd1);
      for (int n = 0; n < 40; n++) add_page({4'hC, 4'(n)}, 1'b1);
      add_slots(4'd8);
      for (int n = 0; n < 40; n++) add_page(lru_pr_pkg::page_type'($urandom), 1'b0);

      // Sample away from the rising edge so that the driver's updates are seen.
      do @(negedge clock);
      while (page_stream.size() != 0 || req_valid || csr_valid ||
             predicted_results.size() != 0);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("lru_page_replacement test passed");
      end else begin
         $display("lru_page_replacement test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
